// ===== hw/rtl/pdp_pkg.sv =====
// Shared constants, payload types and sequencer states for the particle density/pressure block.
package pdp_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W   = 32;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 64;

  // square-root unit
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;
  localparam int STEP_W = $clog2(ROOT_W);

  // negative pressure is scaled by one tenth
  localparam logic [4:0]        DIVISOR     = 5'd10;
  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
  localparam logic [DATA_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                RECIP_SHIFT = 35;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0]  ONE_Q  = REG_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] HALF_Q = DATA_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] query_z;
    logic signed [COORD_W-1:0] neighbor_x;
    logic signed [COORD_W-1:0] neighbor_y;
    logic signed [COORD_W-1:0] neighbor_z;
    logic                      last_neighbor;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]        density_out;
    logic signed [DATA_W-1:0] pressure_out;
    logic                     saturated;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SUM,
    ST_ROOT_GO,
    ST_ROOT,
    ST_CMP,
    ST_V2,
    ST_V2CHK,
    ST_CUBE,
    ST_CUBECHK,
    ST_ACC,
    ST_PSUB,
    ST_PMUL,
    ST_PCHK,
    ST_DIV,
    ST_NEG,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/pdp_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module pdp_isqrt import pdp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= STEP_W'(ROOT_W - 1);
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      cnt  <= cnt - STEP_W'(1);
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/particle_density_pressure.sv =====
// Top level: per-neighbor cubic-kernel density accumulation and pressure output.
// A neighbor that is coincident or has an axis gap of 2^31 or more adds nothing;
// any other neighbor passes the squares, their sum and the bit-serial square root first.
// A last neighbor then passes the pressure steps, and for a negative pressure also the
// reciprocal multiply by ten, and waits on any unread result. One request at a time.
// Reset (synchronous) clears the sum, the overflow flag, rsp_valid and sets R = K = 1.0.
module particle_density_pressure import pdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  state_t state, state_next;

  logic [REG_W-1:0]  kernel_radius;
  logic [REG_W-1:0]  pressure_gain;
  logic [DATA_W-1:0] density_sum;
  logic              sum_overflowed;

  req_t              req_q;
  logic [DATA_W-1:0] dx, dy, dz;
  logic [REG_W-1:0]  v;
  logic [DATA_W-1:0] opnd;
  logic [PROD_W-1:0] prod;
  logic [RAD_W-1:0]  sq_sum;
  logic [DATA_W-1:0] term;
  logic              neg;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] pres;
  logic              psat;

  logic [DATA_W-1:0] mul_a, mul_b;
  logic              sq_start;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  logic signed [DATA_W:0] dxs, dys, dzs;
  logic [DATA_W:0]   ax, ay, az;
  logic              skip;
  logic              root_out;
  logic              v2_over;
  logic              cube_over;
  logic              pres_over;
  logic [DATA_W:0]   acc_sum;
  logic              emit_ok;

  assign cfg_ready = 1'b1;

  pdp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_sum),
    .done     (sq_done),
    .root     (sq_root)
  );

  // datapath conditions
  always_comb begin
    dxs = {req_q.query_x[COORD_W-1], req_q.query_x}
        - {req_q.neighbor_x[COORD_W-1], req_q.neighbor_x};
    dys = {req_q.query_y[COORD_W-1], req_q.query_y}
        - {req_q.neighbor_y[COORD_W-1], req_q.neighbor_y};
    dzs = {req_q.query_z[COORD_W-1], req_q.query_z}
        - {req_q.neighbor_z[COORD_W-1], req_q.neighbor_z};
    ax  = dxs[DATA_W] ? DATA_W'(1'b0) - dxs : dxs;
    ay  = dys[DATA_W] ? DATA_W'(1'b0) - dys : dys;
    az  = dzs[DATA_W] ? DATA_W'(1'b0) - dzs : dzs;
    // far on any axis, or the same point: contributes nothing
    skip = (|ax[DATA_W:DATA_W-1]) || (|ay[DATA_W:DATA_W-1]) || (|az[DATA_W:DATA_W-1])
        || (ax == '0 && ay == '0 && az == '0);
    root_out  = sq_root >= {1'b0, kernel_radius};
    v2_over   = |prod[PROD_W-1:FRAC_BITS+DATA_W];
    cube_over = |prod[PROD_W-1:FRAC_BITS+DATA_W];
    pres_over = |prod[PROD_W-1:FRAC_BITS+DATA_W-1];
    acc_sum   = {1'b0, density_sum} + {1'b0, term};
    emit_ok   = !rsp_valid || rsp_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (req_valid) state_next = ST_DIFF;
      ST_DIFF:    state_next = skip ? ST_ACC : ST_SQX;
      ST_SQX:     state_next = ST_SQY;
      ST_SQY:     state_next = ST_SQZ;
      ST_SQZ:     state_next = ST_SUM;
      ST_SUM:     state_next = ST_ROOT_GO;
      ST_ROOT_GO: state_next = ST_ROOT;
      ST_ROOT:    if (sq_done) state_next = ST_CMP;
      ST_CMP:     state_next = root_out ? ST_ACC : ST_V2;
      ST_V2:      state_next = ST_V2CHK;
      ST_V2CHK:   state_next = v2_over ? ST_ACC : ST_CUBE;
      ST_CUBE:    state_next = ST_CUBECHK;
      ST_CUBECHK: state_next = ST_ACC;
      ST_ACC:     state_next = req_q.last_neighbor ? ST_PSUB : ST_IDLE;
      ST_PSUB:    state_next = ST_PMUL;
      ST_PMUL:    state_next = ST_PCHK;
      ST_PCHK:    state_next = neg ? ST_DIV : ST_EMIT;
      ST_DIV:     state_next = ST_NEG;
      ST_NEG:     state_next = ST_EMIT;
      ST_EMIT:    if (emit_ok) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready = state == ST_IDLE;
    sq_start  = state == ST_ROOT_GO;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_SQX: begin
        mul_a = dx;
        mul_b = dx;
      end
      ST_SQY: begin
        mul_a = dy;
        mul_b = dy;
      end
      ST_SQZ: begin
        mul_a = dz;
        mul_b = dz;
      end
      ST_V2: begin
        mul_a = {1'b0, v};
        mul_b = {1'b0, v};
      end
      ST_CUBE: begin
        mul_a = opnd;
        mul_b = {1'b0, v};
      end
      ST_PMUL: begin
        mul_a = {1'b0, pressure_gain};
        mul_b = opnd;
      end
      ST_DIV: begin
        mul_a = quo;
        mul_b = RECIP_TEN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_radius <= ONE_Q;
      pressure_gain <= ONE_Q;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KERNEL_RADIUS: kernel_radius <= cfg_data[REG_W-1:0];
        REG_PRESSURE_GAIN: pressure_gain <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      density_sum    <= '0;
      sum_overflowed <= 1'b0;
    end else if (state == ST_ACC) begin
      if (acc_sum[DATA_W]) begin
        density_sum    <= '1;
        sum_overflowed <= 1'b1;
      end else begin
        density_sum <= acc_sum[DATA_W-1:0];
      end
    end else if (state == ST_EMIT && emit_ok) begin
      density_sum    <= '0;
      sum_overflowed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_EMIT && emit_ok) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // shared multiplier, product always registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) req_q <= req;
      end
      ST_DIFF: begin
        dx   <= ax[DATA_W-1:0];
        dy   <= ay[DATA_W-1:0];
        dz   <= az[DATA_W-1:0];
        term <= '0;
      end
      ST_SQY:     sq_sum <= prod;
      ST_SQZ:     sq_sum <= sq_sum + prod;
      ST_SUM:     sq_sum <= sq_sum + prod;
      ST_CMP: begin
        term <= '0;
        v    <= kernel_radius - sq_root[REG_W-1:0];
      end
      ST_V2CHK: begin
        term <= '1;
        opnd <= prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
      end
      ST_CUBECHK: begin
        term <= cube_over ? '1 : prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
      end
      ST_PSUB: begin
        neg  <= density_sum < HALF_Q;
        opnd <= (density_sum < HALF_Q) ? HALF_Q - density_sum : density_sum - HALF_Q;
        psat <= sum_overflowed;
      end
      ST_PCHK: begin
        quo  <= prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        if (pres_over) begin
          pres <= {1'b0, {(DATA_W-1){1'b1}}};
          if (!neg) psat <= 1'b1;
        end else begin
          pres <= {1'b0, prod[FRAC_BITS+DATA_W-2:FRAC_BITS]};
        end
      end
      // product of the reduced magnitude and the reciprocal of ten
      ST_NEG:     pres <= DATA_W'(0) - DATA_W'(prod[PROD_W-1:RECIP_SHIFT]);
      ST_EMIT: begin
        if (emit_ok) begin
          rsp.density_out  <= density_sum;
          rsp.pressure_out <= pres;
          rsp.saturated    <= psat;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous one still in progress");

  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_ROOT)
    else $error("square root finished outside its wait state");

  a_rsp_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EMIT)
    else $error("result presented without passing the emit step");

  a_overflow_clamped: assert property (@(posedge clk) disable iff (rst)
    sum_overflowed |-> density_sum == '1)
    else $error("overflow flag set but density sum not clamped");
`endif

endmodule
